>>> rtl/sstf_pkg.sv
package sstf_pkg;

  // Running total width and its saturation point
  localparam int unsigned TOTAL_W = 17;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WAIT,
    ST_EMIT
  } state_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;    // write the incoming item into the store
    logic begin_b; // open the service phase of a batch
    logic rd;      // read the store at the scan index
    logic emit;    // serve the nearest request found by the scan
    logic finish;  // close the batch
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic full_next;  // the item being loaded fills the store
    logic scan_last;  // scan index is at the last stored entry
    logic batch_last; // the request being served is the batch's final one
  } stat_t;

endpackage

>>> rtl/sstf_ctrl.sv
module sstf_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic           last_i,
  input  sstf_pkg::stat_t stat_i,
  output sstf_pkg::cmd_t  cmd_o,
  output logic           busy_o
);
  import sstf_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy_o  = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          cmd_o.load = 1'b1;
          // a full store closes the batch like a marked last item
          if (last_i || stat_i.full_next) begin
            cmd_o.begin_b = 1'b1;
            state_d       = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        cmd_o.rd = 1'b1;
        if (stat_i.scan_last) begin
          state_d = ST_WAIT;
        end
      end
      ST_WAIT: begin
        // last read data is compared in this cycle
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        cmd_o.emit = 1'b1;
        if (stat_i.batch_last) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end else begin
          state_d = ST_SCAN;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |-> (state_q == ST_IDLE))
    else $error("item loaded outside idle");

endmodule

>>> rtl/sstf_dp.sv
module sstf_dp #(
  parameter int unsigned MAX_REQUESTS  = 16,
  parameter int unsigned CYLINDER_BITS = 13
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  sstf_pkg::cmd_t            cmd_i,
  output sstf_pkg::stat_t           stat_o,
  input  logic                      cfg_we_i,
  input  logic [CYLINDER_BITS-1:0]  cfg_data_i,
  input  logic [CYLINDER_BITS-1:0]  req_cyl_i,
  output logic                      res_valid_o,
  output logic [CYLINDER_BITS-1:0]  res_cyl_o,
  output logic [CYLINDER_BITS-1:0]  res_dist_o,
  output logic [sstf_pkg::TOTAL_W-1:0] res_total_o,
  output logic                      res_last_o
);
  import sstf_pkg::*;

  localparam int unsigned IDX_W = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_REQUESTS + 1);
  localparam int unsigned SUM_W =
    ((TOTAL_W > CYLINDER_BITS) ? TOTAL_W : CYLINDER_BITS) + 1;

  logic [CYLINDER_BITS-1:0] store_mem [MAX_REQUESTS];

  logic [CYLINDER_BITS-1:0] start_cyl_q;
  logic [CNT_W-1:0]         count_q, count_d;
  logic [CNT_W-1:0]         served_q, served_d;
  logic [IDX_W-1:0]         idx_q, idx_d;
  logic [MAX_REQUESTS-1:0]  mask_q, mask_d;
  logic                     rd_valid_q;
  logic [IDX_W-1:0]         rd_idx_q;
  logic [CYLINDER_BITS-1:0] rd_data_q;
  logic [CYLINDER_BITS-1:0] head_q, head_d;
  logic [TOTAL_W-1:0]       total_q, total_d;
  logic                     found_q, found_d;
  logic [CYLINDER_BITS-1:0] best_dist_q;
  logic [CYLINDER_BITS-1:0] best_cyl_q;
  logic [IDX_W-1:0]         best_idx_q;
  logic                     res_valid_q;
  logic [CYLINDER_BITS-1:0] res_cyl_q, res_dist_q;
  logic [TOTAL_W-1:0]       res_total_q;
  logic                     res_last_q;

  logic [CYLINDER_BITS-1:0] cand_dist;
  logic                     take;
  logic [SUM_W-1:0]         sum;
  logic [CNT_W-1:0]         count_m1;

  assign count_m1 = count_q - CNT_W'(1);

  assign stat_o.full_next  = (count_q == CNT_W'(MAX_REQUESTS - 1));
  assign stat_o.scan_last  = (CNT_W'(idx_q) == count_m1);
  assign stat_o.batch_last = (served_q == count_m1);

  // distance from the head to the entry just read
  assign cand_dist = (rd_data_q >= head_q) ? (rd_data_q - head_q) : (head_q - rd_data_q);
  assign take = rd_valid_q && !mask_q[rd_idx_q] && (!found_q || (cand_dist < best_dist_q));

  assign sum = SUM_W'(total_q) + SUM_W'(best_dist_q);

  always_comb begin
    count_d  = count_q;
    served_d = served_q;
    idx_d    = idx_q;
    mask_d   = mask_q;
    head_d   = head_q;
    total_d  = total_q;
    found_d  = found_q;
    if (take) begin
      found_d = 1'b1;
    end
    if (cmd_i.load) begin
      count_d = count_q + CNT_W'(1);
    end
    if (cmd_i.begin_b) begin
      head_d   = start_cyl_q;
      total_d  = '0;
      served_d = '0;
      idx_d    = '0;
      found_d  = 1'b0;
    end
    if (cmd_i.rd) begin
      idx_d = idx_q + IDX_W'(1);
    end
    if (cmd_i.emit) begin
      mask_d[best_idx_q] = 1'b1;
      head_d   = best_cyl_q;
      total_d  = (sum > SUM_W'(TOTAL_MAX)) ? TOTAL_MAX : sum[TOTAL_W-1:0];
      served_d = served_q + CNT_W'(1);
      idx_d    = '0;
      found_d  = 1'b0;
    end
    if (cmd_i.finish) begin
      count_d = '0;
      mask_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_cyl_q <= '0;
      count_q     <= '0;
      served_q    <= '0;
      idx_q       <= '0;
      mask_q      <= '0;
      rd_valid_q  <= 1'b0;
      head_q      <= '0;
      total_q     <= '0;
      found_q     <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        start_cyl_q <= cfg_data_i;
      end
      count_q     <= count_d;
      served_q    <= served_d;
      idx_q       <= idx_d;
      mask_q      <= mask_d;
      rd_valid_q  <= cmd_i.rd;
      head_q      <= head_d;
      total_q     <= total_d;
      found_q     <= found_d;
      res_valid_q <= cmd_i.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      store_mem[count_q[IDX_W-1:0]] <= req_cyl_i;
    end
    if (cmd_i.rd) begin
      rd_data_q <= store_mem[idx_q];
      rd_idx_q  <= idx_q;
    end
    if (take) begin
      best_dist_q <= cand_dist;
      best_cyl_q  <= rd_data_q;
      best_idx_q  <= rd_idx_q;
    end
    if (cmd_i.emit) begin
      res_cyl_q   <= best_cyl_q;
      res_dist_q  <= best_dist_q;
      res_total_q <= total_d;
      res_last_q  <= cmd_i.finish;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_cyl_o   = res_cyl_q;
  assign res_dist_o  = res_dist_q;
  assign res_total_o = res_total_q;
  assign res_last_o  = res_last_q;

  a_emit_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> found_q)
    else $error("request served without a candidate");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_REQUESTS))
    else $error("request count beyond store depth");

  a_finish_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |=> (count_q == '0) && (mask_q == '0))
    else $error("batch state not cleared after final result");

endmodule

>>> rtl/shortest_seek_first_scheduler.sv
// Shortest-seek-first request scheduler.
// Items come in on start/busy: an item is taken at a clock edge with start high
// and busy low. Each item writes one request cylinder into the store; the item
// with last_request_i set, or the one that fills the store, closes the batch.
// Items can be loaded back to back while busy is low.
// When a batch of n requests closes, busy rises and the head starts at the
// configured start cylinder. For each served request the block scans all n
// stored entries through the store's single registered read port, picking the
// unserved entry nearest the head (lowest index on ties). Each result appears
// for exactly one cycle with result_valid_o high; last_served_o marks the
// batch's final one. The receiver cannot hold results off. busy falls with the
// final result.
// The start cylinder is written through cfg_valid_i/cfg_ready_o/cfg_data_i;
// ready is high whenever the block is idle.
// Reset clears the batch, the start cylinder and the head; store contents are
// not cleared and are only read after being written in the current batch.
module shortest_seek_first_scheduler #(
  parameter int unsigned MAX_REQUESTS  = 16,
  parameter int unsigned CYLINDER_BITS = 13
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic [CYLINDER_BITS-1:0]     request_cylinder_i,
  input  logic                         last_request_i,
  output logic                         result_valid_o,
  output logic [CYLINDER_BITS-1:0]     served_cylinder_o,
  output logic [CYLINDER_BITS-1:0]     seek_distance_o,
  output logic [sstf_pkg::TOTAL_W-1:0] total_movement_o,
  output logic                         last_served_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [CYLINDER_BITS-1:0]     cfg_data_i
);
  import sstf_pkg::*;

  cmd_t  cmd;
  stat_t stat;
  logic  busy_int;

  assign busy        = busy_int;
  assign cfg_ready_o = ~busy_int;

  sstf_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .last_i  (last_request_i),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy_int)
  );

  sstf_dp #(
    .MAX_REQUESTS  (MAX_REQUESTS),
    .CYLINDER_BITS (CYLINDER_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .cfg_we_i    (cfg_valid_i & ~busy_int),
    .cfg_data_i  (cfg_data_i),
    .req_cyl_i   (request_cylinder_i),
    .res_valid_o (result_valid_o),
    .res_cyl_o   (served_cylinder_o),
    .res_dist_o  (seek_distance_o),
    .res_total_o (total_movement_o),
    .res_last_o  (last_served_o)
  );

endmodule

>>> tb/shortest_seek_first_scheduler_tb.sv
module shortest_seek_first_scheduler_tb;

  import sstf_pkg::TOTAL_W;
  import sstf_pkg::TOTAL_MAX;

  localparam int unsigned CYL_W         = 13;
  localparam int unsigned DEPTH         = 16;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam logic [CYL_W-1:0] CYL_TOP  = '1;

  typedef enum logic {
    ENT_REQ,
    ENT_CFG
  } entry_kind_e;

  typedef struct {
    entry_kind_e kind;
    logic [CYL_W-1:0] cyl;
    logic last;
    int unsigned idle_pct;
  } stim_entry_t;

  typedef struct packed {
    logic [CYL_W-1:0] cyl;
    logic [CYL_W-1:0] seek;
    logic [TOTAL_W-1:0] total;
    logic last;
  } seek_result_t;

  logic clk_i;
  logic rst_ni;
  logic start;
  logic busy;
  logic [CYL_W-1:0] request_cylinder_i;
  logic last_request_i;
  logic result_valid_o;
  logic [CYL_W-1:0] served_cylinder_o;
  logic [CYL_W-1:0] seek_distance_o;
  logic [TOTAL_W-1:0] total_movement_o;
  logic last_served_o;
  logic cfg_valid_i;
  logic cfg_ready_o;
  logic [CYL_W-1:0] cfg_data_i;

  stim_entry_t  request_q[$];
  seek_result_t due_results[$];
  int unsigned  error_cnt = 0;

  // predictor state
  logic [CYL_W-1:0] req_store[DEPTH];
  int unsigned      req_cnt = 0;
  logic [CYL_W-1:0] start_cyl = '0;

  shortest_seek_first_scheduler dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start              (start),
    .busy               (busy),
    .request_cylinder_i (request_cylinder_i),
    .last_request_i     (last_request_i),
    .result_valid_o     (result_valid_o),
    .served_cylinder_o  (served_cylinder_o),
    .seek_distance_o    (seek_distance_o),
    .total_movement_o   (total_movement_o),
    .last_served_o      (last_served_o),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_data_i         (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Serve the closed batch nearest-first, lowest index on ties.
  function automatic void sstf_order();
    logic [CYL_W-1:0]   head;
    logic [TOTAL_W-1:0] total;
    logic [TOTAL_W:0]   sum;
    logic [DEPTH-1:0]   done;
    logic [CYL_W-1:0]   best_d;
    logic [CYL_W-1:0]   d;
    int                 best_i;
    seek_result_t       r;
    head  = start_cyl;
    total = '0;
    done  = '0;
    for (int k = 0; k < req_cnt; k++) begin
      best_i = -1;
      best_d = '0;
      for (int i = 0; i < req_cnt; i++) begin
        if (!done[i]) begin
          d = (req_store[i] >= head) ? req_store[i] - head : head - req_store[i];
          if (best_i < 0 || d < best_d) begin
            best_i = i;
            best_d = d;
          end
        end
      end
      done[best_i] = 1'b1;
      head  = req_store[best_i];
      sum   = total + best_d;
      total = (sum > TOTAL_MAX) ? TOTAL_MAX : sum[TOTAL_W-1:0];
      r.cyl   = head;
      r.seek  = best_d;
      r.total = total;
      r.last  = (k + 1 == req_cnt);
      due_results.push_back(r);
    end
  endfunction

  function automatic void take_request(logic [CYL_W-1:0] cyl, logic last);
    if (req_cnt < DEPTH) begin
      req_store[req_cnt] = cyl;
      req_cnt++;
    end
    if (last || req_cnt >= DEPTH) begin
      sstf_order();
      req_cnt = 0;
    end
  endfunction

  // driver
  stim_entry_t drv_ent;
  logic        nx_start;
  logic        nx_cfg;
  int unsigned quiet_cnt = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start              <= 1'b0;
      cfg_valid_i        <= 1'b0;
      request_cylinder_i <= '0;
      last_request_i     <= 1'b0;
      cfg_data_i         <= '0;
    end else begin
      nx_start = start;
      nx_cfg   = cfg_valid_i;
      if (start && !busy) begin
        take_request(request_cylinder_i, last_request_i);
        nx_start = 1'b0;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        start_cyl = cfg_data_i;
        nx_cfg    = 1'b0;
      end
      if (!start && !busy && due_results.size() == 0) quiet_cnt++;
      else quiet_cnt = 0;
      if (!nx_start && !nx_cfg && request_q.size() != 0) begin
        drv_ent = request_q[0];
        if (drv_ent.kind == ENT_CFG) begin
          // register writes only once the block has drained
          if (quiet_cnt >= SETTLE_CYCLES) begin
            void'(request_q.pop_front());
            nx_cfg = 1'b1;
            cfg_data_i <= drv_ent.cyl;
          end
        end else if ($urandom_range(99) >= drv_ent.idle_pct) begin
          void'(request_q.pop_front());
          nx_start = 1'b1;
          request_cylinder_i <= drv_ent.cyl;
          last_request_i     <= drv_ent.last;
        end
      end
      start       <= nx_start;
      cfg_valid_i <= nx_cfg;
    end
  end

  // monitor
  seek_result_t want;
  seek_result_t got;

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      got = '{served_cylinder_o, seek_distance_o, total_movement_o, last_served_o};
      if (due_results.size() == 0) begin
        $display("%0t: unexpected result cyl=%0d dist=%0d total=%0d last=%0b",
                 $time, got.cyl, got.seek, got.total, got.last);
        error_cnt++;
      end else begin
        want = due_results.pop_front();
        if (got !== want) begin
          $display("%0t: mismatch exp cyl=%0d dist=%0d total=%0d last=%0b",
                   $time, want.cyl, want.seek, want.total, want.last);
          $display("%0t:          got cyl=%0d dist=%0d total=%0d last=%0b",
                   $time, got.cyl, got.seek, got.total, got.last);
          error_cnt++;
        end
      end
    end
  end

  task automatic push_req(logic [CYL_W-1:0] cyl, logic last, int unsigned pct);
    request_q.push_back('{ENT_REQ, cyl, last, pct});
  endtask

  task automatic push_cfg(logic [CYL_W-1:0] cyl);
    request_q.push_back('{ENT_CFG, cyl, 1'b0, 0});
  endtask

  // One batch of len requests, either spread wide or clustered for ties.
  task automatic push_batch(int unsigned len, int unsigned pct);
    logic [CYL_W-1:0] base;
    logic             clustered;
    logic             last;
    base      = CYL_W'($urandom_range(CYL_TOP));
    clustered = 1'($urandom_range(1));
    for (int i = 0; i < len; i++) begin
      if (i + 1 < len) last = 1'b0;
      else if (len == DEPTH) last = 1'($urandom_range(1));
      else last = 1'b1;
      if (clustered) push_req(CYL_W'(base + $urandom_range(6) - 3), last, pct);
      else push_req(CYL_W'($urandom_range(CYL_TOP)), last, pct);
    end
  endtask

  int unsigned phase_pct[3] = '{20, 85, 0};
  int unsigned n_items;
  int unsigned len;

  initial begin
    rst_ni = 1'b0;

    // directed: field extremes, equal-distance ties, store full
    push_cfg('0);
    push_req('0, 1'b1, 20);
    push_req(CYL_TOP, 1'b1, 20);
    push_cfg(13'd4000);
    push_req(13'd4010, 1'b0, 20);
    push_req(13'd3990, 1'b0, 20);
    push_req(13'd4010, 1'b0, 20);
    push_req(CYL_TOP, 1'b0, 20);
    push_req('0, 1'b1, 20);
    push_cfg(CYL_TOP);
    for (int i = 0; i < DEPTH; i++) push_req((i % 2) ? '0 : CYL_TOP, 1'b0, 20);

    for (int p = 0; p < 3; p++) begin
      push_cfg(CYL_W'($urandom_range(CYL_TOP)));
      n_items = 0;
      while (n_items < 20) begin
        len = ($urandom_range(3) == 0) ? DEPTH : $urandom_range(1, DEPTH - 1);
        push_batch(len, phase_pct[p]);
        n_items += len;
        if ($urandom_range(3) == 0) push_cfg(CYL_W'($urandom_range(CYL_TOP)));
      end
    end

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (request_q.size() != 0 || start || cfg_valid_i || due_results.size() != 0)
      @(posedge clk_i);
    repeat (40) @(posedge clk_i);

    if (error_cnt == 0) begin
      $display("shortest_seek_first_scheduler_tb: PASS");
    end else begin
      $display("shortest_seek_first_scheduler_tb: FAIL");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("shortest_seek_first_scheduler_tb: FAIL");
    $finish;
  end

endmodule
